/* sv/bshe_pkg.sv */
// ----------------------------------------------------------------------------
// bshe_pkg
// Shared types and constants of the boot-ROM serial host engine.
// ----------------------------------------------------------------------------
`default_nettype none
package bshe_pkg;
    typedef enum logic [3:0] {
        P_IDLE, P_HS, P_ECHO_CMD, P_ECHO_ADDR, P_ECHO_LEN, P_ECHO_SIG,
        P_ECHO_VAL, P_HWCODE, P_STATUS, P_PAYLOAD, P_READ_DATA, P_CHECKSUM,
        P_END_STATUS
    } phase_t;

    localparam logic [2:0] C_HS = 3'd0;
    localparam logic [2:0] C_HW = 3'd1;
    localparam logic [2:0] C_SEND = 3'd2;
    localparam logic [2:0] C_JUMP = 3'd3;
    localparam logic [2:0] C_READ = 3'd4;
    localparam logic [2:0] C_WRITE = 3'd5;

    localparam logic [1:0] A_START = 2'd0;
    localparam logic [1:0] A_RX = 2'd1;
    localparam logic [1:0] A_PAY = 2'd2;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_ECHO = 3'd1;
    localparam logic [2:0] ST_NZ = 3'd2;
    localparam logic [2:0] ST_RETRY = 3'd3;
    localparam logic [2:0] ST_REJECT = 3'd4;

    localparam logic [1:0] K_HW = 2'd0;
    localparam logic [1:0] K_READ = 2'd1;
    localparam logic [1:0] K_SUM = 2'd2;

    localparam logic [2:0] R_RETRY = 3'd5;
    localparam logic [7:0] RETRY_LIMIT_RESET = 8'd16;

    typedef logic [7:0] opcodes_t [5];

    function automatic logic [7:0] hs_byte(input logic [1:0] i);
        case (i)
            2'd0: hs_byte = 8'ha0;
            2'd1: hs_byte = 8'h0a;
            2'd2: hs_byte = 8'h50;
            default: hs_byte = 8'h05;
        endcase
    endfunction

    typedef struct packed {
        logic [31:0] tx_data;
        logic [2:0]  tx_count;
        logic [31:0] word_out;
        logic        word_valid;
        logic [1:0]  word_kind;
        logic        need_payload;
        logic        finished;
        logic [2:0]  status;
    } result_t;
endpackage
`default_nettype wire

/* sv/bshe_cfg.sv */
// ----------------------------------------------------------------------------
// bshe_cfg
// Configuration registers: command bytes and handshake retry limit.
// ----------------------------------------------------------------------------
`default_nettype none
module bshe_cfg (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_valid,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [7:0]        cfg_data,
    output bshe_pkg::opcodes_t     opcodes,
    output logic [7:0]             retry_limit
);
    bshe_pkg::opcodes_t op_reg;
    logic [7:0] lim_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg[0] <= 8'hfd;
            op_reg[1] <= 8'hd7;
            op_reg[2] <= 8'hd5;
            op_reg[3] <= 8'hd1;
            op_reg[4] <= 8'hd4;
            lim_reg <= bshe_pkg::RETRY_LIMIT_RESET;
        end else if (cfg_valid) begin
            if (cfg_index < bshe_pkg::R_RETRY) op_reg[cfg_index] <= cfg_data;
            else if (cfg_index == bshe_pkg::R_RETRY) lim_reg <= cfg_data;
        end
    end

    assign opcodes = op_reg;
    assign retry_limit = lim_reg;
endmodule
`default_nettype wire

/* sv/bshe_core.sv */
// ----------------------------------------------------------------------------
// bshe_core
// Protocol state machine; one item is processed per accepted cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module bshe_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               step,
    input  wire logic [1:0]         action,
    input  wire logic [2:0]         command,
    input  wire logic [31:0]        address,
    input  wire logic [31:0]        length,
    input  wire logic [31:0]        write_value,
    input  wire logic [7:0]         rx_byte,
    input  wire logic [7:0]         payload_byte,
    input  wire bshe_pkg::opcodes_t opcodes,
    input  wire logic [7:0]         retry_limit,
    output bshe_pkg::result_t       res
);
    bshe_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  cmd_reg, cmd_next;
    logic [1:0]  pos_reg, pos_next;
    logic [31:0] asm_reg, asm_next;
    logic [31:0] addr_reg, addr_next, len_reg, len_next, val_reg, val_next;
    logic [31:0] rem_reg, rem_next;
    logic [7:0]  retry_reg, retry_next;
    logic [1:0]  hs_reg, hs_next;
    logic [15:0] sum_reg, sum_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= bshe_pkg::P_IDLE;
            cmd_reg <= 3'd0;
            pos_reg <= 2'd0;
            asm_reg <= 32'd0;
            addr_reg <= 32'd0;
            len_reg <= 32'd0;
            val_reg <= 32'd0;
            rem_reg <= 32'd0;
            retry_reg <= 8'd0;
            hs_reg <= 2'd0;
            sum_reg <= 16'd0;
        end else if (step) begin
            phase_reg <= phase_next;
            cmd_reg <= cmd_next;
            pos_reg <= pos_next;
            asm_reg <= asm_next;
            addr_reg <= addr_next;
            len_reg <= len_next;
            val_reg <= val_next;
            rem_reg <= rem_next;
            retry_reg <= retry_next;
            hs_reg <= hs_next;
            sum_reg <= sum_next;
        end
    end

    logic [2:0]  need;
    logic [31:0] w;
    logic        rej;

    always_comb begin
        phase_next = phase_reg;
        cmd_next = cmd_reg;
        pos_next = pos_reg;
        asm_next = asm_reg;
        addr_next = addr_reg;
        len_next = len_reg;
        val_next = val_reg;
        rem_next = rem_reg;
        retry_next = retry_reg;
        hs_next = hs_reg;
        sum_next = sum_reg;
        res = '0;
        rej = 1'b0;
        need = 3'd2;
        w = 32'd0;
        case (action)
            bshe_pkg::A_START: begin
                if (phase_reg != bshe_pkg::P_IDLE || command > bshe_pkg::C_WRITE) begin
                    rej = 1'b1;
                end else begin
                    cmd_next = command;
                    pos_next = 2'd0;
                    asm_next = 32'd0;
                    addr_next = address;
                    len_next = length;
                    val_next = write_value;
                    res.tx_count = 3'd1;
                    if (command == bshe_pkg::C_HS) begin
                        retry_next = 8'd0;
                        hs_next = 2'd0;
                        phase_next = bshe_pkg::P_HS;
                        res.tx_data = {24'd0, bshe_pkg::hs_byte(2'd0)};
                    end else begin
                        phase_next = bshe_pkg::P_ECHO_CMD;
                        res.tx_data = {24'd0, opcodes[command - 3'd1]};
                    end
                end
            end
            bshe_pkg::A_RX: begin
                if (phase_reg == bshe_pkg::P_IDLE || phase_reg == bshe_pkg::P_PAYLOAD) begin
                    rej = 1'b1;
                end else if (phase_reg == bshe_pkg::P_HS) begin
                    if (rx_byte == ~bshe_pkg::hs_byte(hs_reg)) begin
                        if (hs_reg == 2'd3) begin
                            res.finished = 1'b1;
                            phase_next = bshe_pkg::P_IDLE;
                        end else begin
                            hs_next = hs_reg + 2'd1;
                            res.tx_data = {24'd0, bshe_pkg::hs_byte(hs_reg + 2'd1)};
                            res.tx_count = 3'd1;
                        end
                    end else begin
                        retry_next = retry_reg + 8'd1;
                        if (retry_next >= retry_limit) begin
                            res.finished = 1'b1;
                            res.status = bshe_pkg::ST_RETRY;
                            phase_next = bshe_pkg::P_IDLE;
                        end else begin
                            hs_next = 2'd0;
                            res.tx_data = {24'd0, bshe_pkg::hs_byte(2'd0)};
                            res.tx_count = 3'd1;
                        end
                    end
                end else begin
                    case (phase_reg)
                        bshe_pkg::P_ECHO_CMD: need = 3'd1;
                        bshe_pkg::P_ECHO_ADDR, bshe_pkg::P_ECHO_LEN, bshe_pkg::P_ECHO_SIG,
                        bshe_pkg::P_ECHO_VAL, bshe_pkg::P_READ_DATA: need = 3'd4;
                        default: need = 3'd2;
                    endcase
                    asm_next = {asm_reg[23:0], rx_byte};
                    if ({1'b0, pos_reg} + 3'd1 < need) begin
                        pos_next = pos_reg + 2'd1;
                    end else begin
                        pos_next = 2'd0;
                        w = asm_next;
                        if (need == 3'd1) w = {24'd0, asm_next[7:0]};
                        else if (need == 3'd2) w = {16'd0, asm_next[15:0]};
                        case (phase_reg)
                            bshe_pkg::P_ECHO_CMD: begin
                                if (cmd_reg < 3'd1 || cmd_reg > 3'd5 ||
                                    w != {24'd0, opcodes[cmd_reg - 3'd1]}) begin
                                    res.finished = 1'b1;
                                    res.status = bshe_pkg::ST_ECHO;
                                    phase_next = bshe_pkg::P_IDLE;
                                end else if (cmd_reg == bshe_pkg::C_HW) begin
                                    phase_next = bshe_pkg::P_HWCODE;
                                end else begin
                                    res.tx_data = addr_reg;
                                    res.tx_count = 3'd4;
                                    phase_next = bshe_pkg::P_ECHO_ADDR;
                                end
                            end
                            bshe_pkg::P_ECHO_ADDR: begin
                                if (w != addr_reg) begin
                                    res.finished = 1'b1;
                                    res.status = bshe_pkg::ST_ECHO;
                                    phase_next = bshe_pkg::P_IDLE;
                                end else if (cmd_reg == bshe_pkg::C_SEND ||
                                             cmd_reg == bshe_pkg::C_READ) begin
                                    res.tx_data = len_reg;
                                    res.tx_count = 3'd4;
                                    phase_next = bshe_pkg::P_ECHO_LEN;
                                end else if (cmd_reg == bshe_pkg::C_WRITE) begin
                                    res.tx_data = val_reg;
                                    res.tx_count = 3'd4;
                                    phase_next = bshe_pkg::P_ECHO_VAL;
                                end else begin
                                    phase_next = bshe_pkg::P_STATUS;
                                end
                            end
                            bshe_pkg::P_ECHO_LEN: begin
                                if (w != len_reg) begin
                                    res.finished = 1'b1;
                                    res.status = bshe_pkg::ST_ECHO;
                                    phase_next = bshe_pkg::P_IDLE;
                                end else if (cmd_reg == bshe_pkg::C_SEND) begin
                                    res.tx_count = 3'd4;
                                    phase_next = bshe_pkg::P_ECHO_SIG;
                                end else begin
                                    phase_next = bshe_pkg::P_STATUS;
                                end
                            end
                            bshe_pkg::P_ECHO_SIG, bshe_pkg::P_ECHO_VAL: begin
                                if (w != ((phase_reg == bshe_pkg::P_ECHO_SIG) ? 32'd0
                                                                             : val_reg)) begin
                                    res.finished = 1'b1;
                                    res.status = bshe_pkg::ST_ECHO;
                                    phase_next = bshe_pkg::P_IDLE;
                                end else begin
                                    phase_next = bshe_pkg::P_STATUS;
                                end
                            end
                            bshe_pkg::P_HWCODE: begin
                                res.word_out = w;
                                res.word_valid = 1'b1;
                                res.word_kind = bshe_pkg::K_HW;
                                phase_next = bshe_pkg::P_STATUS;
                            end
                            bshe_pkg::P_STATUS: begin
                                if (w != 32'd0) begin
                                    res.finished = 1'b1;
                                    res.status = bshe_pkg::ST_NZ;
                                    phase_next = bshe_pkg::P_IDLE;
                                end else begin
                                    rem_next = len_reg;
                                    if (cmd_reg == bshe_pkg::C_SEND) begin
                                        phase_next = (len_reg != 32'd0) ?
                                            bshe_pkg::P_PAYLOAD : bshe_pkg::P_CHECKSUM;
                                    end else if (cmd_reg == bshe_pkg::C_READ) begin
                                        phase_next = (len_reg != 32'd0) ?
                                            bshe_pkg::P_READ_DATA : bshe_pkg::P_END_STATUS;
                                    end else begin
                                        res.finished = 1'b1;
                                        phase_next = bshe_pkg::P_IDLE;
                                    end
                                end
                            end
                            bshe_pkg::P_READ_DATA: begin
                                res.word_out = w;
                                res.word_valid = 1'b1;
                                res.word_kind = bshe_pkg::K_READ;
                                rem_next = rem_reg - 32'd1;
                                if (rem_next == 32'd0) phase_next = bshe_pkg::P_END_STATUS;
                            end
                            bshe_pkg::P_CHECKSUM: begin
                                sum_next = w[15:0];
                                phase_next = bshe_pkg::P_END_STATUS;
                            end
                            default: begin
                                if (cmd_reg == bshe_pkg::C_SEND) begin
                                    res.word_out = {16'd0, sum_reg};
                                    res.word_valid = 1'b1;
                                    res.word_kind = bshe_pkg::K_SUM;
                                end
                                res.finished = 1'b1;
                                res.status = (w != 32'd0) ? bshe_pkg::ST_NZ : bshe_pkg::ST_OK;
                                phase_next = bshe_pkg::P_IDLE;
                            end
                        endcase
                    end
                end
            end
            bshe_pkg::A_PAY: begin
                if (phase_reg != bshe_pkg::P_PAYLOAD) begin
                    rej = 1'b1;
                end else begin
                    res.tx_data = {24'd0, payload_byte};
                    res.tx_count = 3'd1;
                    rem_next = rem_reg - 32'd1;
                    if (rem_next == 32'd0) phase_next = bshe_pkg::P_CHECKSUM;
                end
            end
            default: rej = 1'b1;
        endcase
        if (rej) res.status = bshe_pkg::ST_REJECT;
        res.need_payload = (phase_next == bshe_pkg::P_PAYLOAD);
    end
endmodule
`default_nettype wire

/* sv/bootrom_serial_host_engine_top.sv */
// ----------------------------------------------------------------------------
// bootrom_serial_host_engine_top
// Host side of a boot-ROM serial download exchange.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                Payload
// s_       in         s_valid / s_ready        action, command, args, bytes
// m_       out        m_valid / m_ready        tx, reported word, status
// cfg_     in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// Each accepted item yields its result word in the next cycle.
// The state machine computes the result and the result register holds it.
// A new item is taken while the output register is empty or being read.
// Reset restores the default command bytes and returns the engine to idle.
// ----------------------------------------------------------------------------
`default_nettype none
module bootrom_serial_host_engine_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_action,
    input  wire logic [2:0]  s_command,
    input  wire logic [31:0] s_address,
    input  wire logic [31:0] s_length,
    input  wire logic [31:0] s_write_value,
    input  wire logic [7:0]  s_rx_byte,
    input  wire logic [7:0]  s_payload_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_tx_data,
    output logic [2:0]       m_tx_count,
    output logic [31:0]      m_word_out,
    output logic             m_word_valid,
    output logic [1:0]       m_word_kind,
    output logic             m_need_payload,
    output logic             m_finished,
    output logic [2:0]       m_status,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    bshe_pkg::opcodes_t opcodes;
    logic [7:0] retry_limit;
    bshe_pkg::result_t res, out_reg;
    logic valid_reg, step;

    assign cfg_ready = 1'b1;
    assign s_ready = !valid_reg || m_ready;
    assign step = s_valid && s_ready;

    bshe_cfg u_cfg (
        .aclk(aclk), .aresetn(aresetn), .cfg_valid(cfg_valid),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .opcodes(opcodes), .retry_limit(retry_limit)
    );

    bshe_core u_core (
        .aclk(aclk), .aresetn(aresetn), .step(step),
        .action(s_action), .command(s_command), .address(s_address),
        .length(s_length), .write_value(s_write_value), .rx_byte(s_rx_byte),
        .payload_byte(s_payload_byte), .opcodes(opcodes),
        .retry_limit(retry_limit), .res(res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) out_reg <= res;
    end

    assign m_valid = valid_reg;
    assign m_tx_data = out_reg.tx_data;
    assign m_tx_count = out_reg.tx_count;
    assign m_word_out = out_reg.word_out;
    assign m_word_valid = out_reg.word_valid;
    assign m_word_kind = out_reg.word_kind;
    assign m_need_payload = out_reg.need_payload;
    assign m_finished = out_reg.finished;
    assign m_status = out_reg.status;
endmodule
`default_nettype wire
